### src/multisine_generator_defines.svh
// ----------------------------------------------------------------------------
// multisine generator assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTISINE_GENERATOR_DEFINES_SVH
`define MULTISINE_GENERATOR_DEFINES_SVH

// consequent checked in the same cycle
`define MSINE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define MSINE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/msine_pkg.sv
// ----------------------------------------------------------------------------
// msine_pkg
// shared types, register codes and sine table generation for the multisine
// generator
// ----------------------------------------------------------------------------
package msine_pkg;

   localparam int PHASE_W       = 32;
   localparam int SINE_W        = 15;
   localparam int AMP_W         = 16;
   localparam int MULT_W        = 4;
   localparam int HARM_W        = 28;
   localparam int MAX_HARMONICS = 7;
   localparam int SAMPLE_W      = 27;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_STEP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HARMONICS = 2'd2;

   localparam logic [PHASE_W-1:0] BASE_STEP_RESET = 32'd683565;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RESET = 16'd1024;
   localparam logic [HARM_W-1:0]  HARMONICS_RESET = 28'h6497531;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // fixed point constants for the table build
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] SINE_DIVS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef struct packed {
      logic valid;
      logic restart;
   } ctrl_type;

   // quarter-wave entry k of 2^tb, q30 horner taylor series through x^13
   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned tb);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] s;
      logic [63:0] r;
      int          j;
      x  = (64'(k) * HALF_PI_Q30) >> tb;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (j = 0; j < 6; j++) begin
         d = ((x2 * t) >> 30) / SINE_DIVS[j];
         t = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      end
      s = (x * t) >> 30;
      r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      return (r > 64'd32767) ? {SINE_W{1'b1}} : r[SINE_W-1:0];
   endfunction

endpackage

### src/msine_cell.sv
// ----------------------------------------------------------------------------
// msine_cell
// one tone: phase accumulator, quarter-wave sine rom and a stage of the
// running sum that moves down the row of cells
// ----------------------------------------------------------------------------
`include "multisine_generator_defines.svh"

module msine_cell
   import msine_pkg::*;
#(
   parameter int                 SINE_TABLE_BITS = 10,
   parameter int                 SUM_W           = 19,
   parameter logic [PHASE_W-1:0] INIT_PHASE      = '0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic [MULT_W-1:0]       tone_mult,
   input  logic [PHASE_W-1:0]      base_step,
   input  ctrl_type                link_in,
   input  logic signed [SUM_W-1:0] sum_in,
   output ctrl_type                link_out,
   output logic signed [SUM_W-1:0] sum_out
);

   localparam int QUARTER_LEN = 1 << SINE_TABLE_BITS;

   typedef logic [SINE_W-1:0] rom_type [QUARTER_LEN+1];

   function automatic rom_type build_rom();
      rom_type rom;
      int      k;
      for (k = 0; k <= QUARTER_LEN; k++) begin
         rom[k] = sine_entry(unsigned'(k), unsigned'(SINE_TABLE_BITS));
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();
   localparam logic [SINE_TABLE_BITS:0] QUARTER_POS = {1'b1, {SINE_TABLE_BITS{1'b0}}};

   logic [PHASE_W-1:0]         phase_ff;
   logic [PHASE_W-1:0]         phase_in;
   logic [PHASE_W-1:0]         inc_ff;
   logic [PHASE_W+MULT_W-1:0]  inc_full;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [SINE_TABLE_BITS:0]   pos;
   ctrl_type                   c1_ff;
   ctrl_type                   c2_ff;
   logic [SINE_W-1:0]          mag_ff;
   logic                       neg_ff;
   logic signed [SUM_W-1:0]    sum_d_ff;
   logic signed [SUM_W-1:0]    sum_out_ff;
   logic signed [SUM_W-1:0]    mag_ext;
   logic signed [SUM_W-1:0]    sine_val;

   assign inc_full = base_step * tone_mult;
   assign phase_in = (link_in.restart ? INIT_PHASE : phase_ff) + inc_ff;

   // quadrants 1 and 3 read the table mirrored
   assign idx = phase_in[PHASE_W-3 -: SINE_TABLE_BITS];
   assign pos = phase_in[PHASE_W-2] ? (QUARTER_POS - {1'b0, idx}) : {1'b0, idx};

   assign mag_ext  = SUM_W'(mag_ff);
   assign sine_val = neg_ff ? -mag_ext : mag_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= INIT_PHASE;
         c1_ff    <= '0;
         c2_ff    <= '0;
      end else if (en) begin
         c1_ff <= link_in;
         c2_ff <= c1_ff;
         if (link_in.valid) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      inc_ff <= inc_full[PHASE_W-1:0];
      if (en) begin
         mag_ff     <= SINE_ROM[pos];
         neg_ff     <= phase_in[PHASE_W-1];
         sum_d_ff   <= sum_in;
         sum_out_ff <= sum_d_ff + sine_val;
      end
   end

   assign link_out = c2_ff;
   assign sum_out  = sum_out_ff;

   `MSINE_ASSERT_NEXT(a_restart_reload, en && link_in.valid && link_in.restart,
      phase_ff == INIT_PHASE + $past(inc_ff), "restart did not reload the tone phase")
   `MSINE_ASSERT_NEXT(a_phase_hold, !en, $stable(phase_ff),
      "tone phase moved while the row was stalled")

endmodule

### src/msine_scale.sv
// ----------------------------------------------------------------------------
// msine_scale
// amplitude multiply, floor shift and saturation, followed by the output
// register and skid stage that decouple the row from the receiver
// ----------------------------------------------------------------------------
`include "multisine_generator_defines.svh"

module msine_scale
   import msine_pkg::*;
#(
   parameter int SUM_W = 19
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_type                   ctrl_in,
   input  logic signed [SUM_W-1:0]    sum_in,
   input  logic [AMP_W-1:0]           amplitude,
   output logic                       en,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

   localparam int PROD_W = SUM_W + AMP_W + 1;
   localparam int RES_W  = PROD_W - 8;
   localparam int EXT_W  = (RES_W > SAMPLE_W) ? RES_W : SAMPLE_W;
   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SAMPLE_MAX);
   localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(SAMPLE_MIN);

   logic                       pv_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [RES_W-1:0]    res;
   logic signed [EXT_W-1:0]    res_ext;
   logic signed [SAMPLE_W-1:0] sat;
   logic                       take;
   logic                       out_v_ff;
   logic                       skid_v_ff;
   logic signed [SAMPLE_W-1:0] out_ff;
   logic signed [SAMPLE_W-1:0] skid_ff;

   assign en      = !skid_v_ff;
   assign take    = pv_ff && en;
   assign prod_in = PROD_W'(sum_in) * PROD_W'($signed({1'b0, amplitude}));

   // arithmetic shift gives the floor of the division by 256
   assign res     = prod_ff[PROD_W-1:8];
   assign res_ext = EXT_W'(res);

   always_comb begin
      if (res_ext > SAT_HI) begin
         sat = SAMPLE_MAX;
      end else if (res_ext < SAT_LO) begin
         sat = SAMPLE_MIN;
      end else begin
         sat = res_ext[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff     <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) begin
            pv_ff <= ctrl_in.valid;
         end
         if (!out_v_ff || rsp_ready) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= take;
            end
         end else if (take) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
      if (!out_v_ff || rsp_ready) begin
         out_ff <= skid_v_ff ? skid_ff : sat;
      end else if (take) begin
         skid_ff <= sat;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_sample = out_ff;

   `MSINE_ASSERT_NOW(a_skid_behind_out, skid_v_ff, out_v_ff,
      "skid stage holds a request while the output register is empty")
   `MSINE_ASSERT_NEXT(a_skid_kept, skid_v_ff && !rsp_ready, skid_v_ff,
      "skid stage dropped a request while the receiver stalled")

endmodule

### src/multisine_generator.sv
// ----------------------------------------------------------------------------
// multisine_generator
// multi-tone direct digital synthesis: one summed, scaled sample per request
// ----------------------------------------------------------------------------
// usage:
//   each request on req_valid/req_ready is one tick; req_restart reloads the
//   evenly spaced start phases before that tick's advance. every request
//   gives exactly one rsp_sample on rsp_valid/rsp_ready, in order.
//   csr_wr_en/csr_index/csr_wdata write base step, amplitude and harmonic
//   multipliers; write them only while no request is in flight.
// throughput: one request per cycle while req_ready is high. the tones sit
//   in a row of cells, each advancing its phase and adding its sine to the
//   running sum after its neighbor; requests stream through back to back.
// path: after acceptance a request passes the input register, the registers
//   of each tone cell, the amplitude multiply register and the output
//   register before its sample is valid on rsp_valid.
// reset: synchronous; csr registers return to their defaults, phases to the
//   start phases and the pipeline empties. the sine roms are constants.
// stall: while the receiver holds rsp_ready low an extra skid stage takes
//   one more sample; once it is full the whole row freezes and req_ready
//   drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module multisine_generator
   import msine_pkg::*;
#(
   parameter int NUM_TONES       = 7,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SUM_W = SINE_W + 1 + $clog2(NUM_TONES);

   logic [PHASE_W-1:0]      base_step_ff;
   logic [AMP_W-1:0]        amplitude_ff;
   logic [HARM_W-1:0]       harm_ff;
   ctrl_type                in_ctrl_ff;
   logic                    stage_en;
   ctrl_type                link [NUM_TONES+1];
   logic signed [SUM_W-1:0] sums [NUM_TONES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff <= BASE_STEP_RESET;
         amplitude_ff <= AMPLITUDE_RESET;
         harm_ff      <= HARMONICS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_STEP: base_step_ff <= csr_wdata[PHASE_W-1:0];
            CSR_AMPLITUDE: amplitude_ff <= csr_wdata[AMP_W-1:0];
            CSR_HARMONICS: harm_ff      <= csr_wdata[HARM_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = stage_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctrl_ff <= '0;
      end else if (stage_en) begin
         in_ctrl_ff.valid   <= req_valid;
         in_ctrl_ff.restart <= req_restart;
      end
   end

   assign link[0] = in_ctrl_ff;
   assign sums[0] = '0;

   for (genvar g = 0; g < NUM_TONES; g++) begin : g_tone
      localparam logic [PHASE_W-1:0] INIT_PHASE =
         PHASE_W'((64'(g) << PHASE_W) / NUM_TONES);

      logic [MULT_W-1:0] tone_mult;

      // tones past the register's seven nibbles stand still
      if (g < MAX_HARMONICS) begin : g_mult
         assign tone_mult = harm_ff[g*MULT_W +: MULT_W];
      end else begin : g_zero
         assign tone_mult = '0;
      end

      msine_cell #(
         .SINE_TABLE_BITS (SINE_TABLE_BITS),
         .SUM_W           (SUM_W),
         .INIT_PHASE      (INIT_PHASE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (stage_en),
         .tone_mult (tone_mult),
         .base_step (base_step_ff),
         .link_in   (link[g]),
         .sum_in    (sums[g]),
         .link_out  (link[g+1]),
         .sum_out   (sums[g+1])
      );
   end

   msine_scale #(
      .SUM_W (SUM_W)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (link[NUM_TONES]),
      .sum_in     (sums[NUM_TONES]),
      .amplitude  (amplitude_ff),
      .en         (stage_en),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

endmodule
